### hdl/msmp_pkg.sv
package msmp_pkg;

  // Field widths
  localparam int UNI_W      = 16;
  localparam int POS_W      = 16;
  localparam int DENS_W     = 16;
  localparam int DELTA_W    = 14;
  localparam int TOTAL_W    = 20;
  localparam int SQ_W       = 31;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Configuration map
  localparam int            CFG_ADDR_W          = 2;
  localparam int            CFG_DATA_W          = 32;
  localparam logic [1:0]    REG_STEP_HALF_WIDTH = 2'd0;
  localparam logic [13:0]   DELTA_RESET         = 14'd2048;

  // log2(e) in Q.16
  localparam logic [16:0]   LOG2E_Q16 = 17'd94548;
  // 2^(-1/64) in Q0.32
  localparam logic [63:0]   STEP_DOWN_Q32 = 64'd4248701969;

  typedef logic [63:0][15:0] exp_table_t;

  // One command per sequencer step
  typedef struct packed {
    logic load;
    logic off;
    logic prop;
    logic sq;
    logic expo;
    logic dens;
    logic commit;
  } msmp_cmd_t;

  // Table of 2^(-i/64) in Q0.16, built by repeated scaling of 2^31
  function automatic exp_table_t build_exp_table();
    logic [63:0] e;
    logic [63:0] v;
    exp_table_t  tab;
    e = 64'd1 << 31;
    for (int i = 0; i < 64; i++) begin
      if (i > 0) begin
        e = (e * STEP_DOWN_Q32 + (64'd1 << 31)) >> 32;
      end
      v = (e + (64'd1 << 14)) >> 15;
      tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
    return tab;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

  // Density of a constant position, used for the reset value only
  function automatic logic [15:0] density_const(logic signed [15:0] x, int frac_bits);
    longint            sx;
    longint unsigned   sq;
    longint unsigned   t;
    longint unsigned   k;
    longint unsigned   idx;
    longint unsigned   e;
    longint unsigned   f;
    int                fb;
    exp_table_t        tab;
    tab = build_exp_table();
    sx  = longint'(x);
    sq  = longint'(sx * sx);
    t   = (sq * 64'd94548) >> 1;
    fb  = 2 * frac_bits + 16;
    k   = t >> fb;
    idx = (t >> (fb - 6)) & 64'd63;
    if (k >= 64'd17) begin
      return 16'd0;
    end
    e = 64'(tab[idx[5:0]]) >> k;
    f = (sq * e) >> (2 * frac_bits);
    return (f > 64'd65535) ? 16'hFFFF : f[15:0];
  endfunction

endpackage

### hdl/msmp_ctrl.sv
module msmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output msmp_pkg::msmp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFF,
    S_PROP,
    S_SQ,
    S_EXP,
    S_DENS,
    S_CMP
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Decode the step commands from the state, the input handshake and the output slot
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_tready && in_tvalid;
    cmd_o.off    = (state_r == S_OFF);
    cmd_o.prop   = (state_r == S_PROP);
    cmd_o.sq     = (state_r == S_SQ);
    cmd_o.expo   = (state_r == S_EXP);
    cmd_o.dens   = (state_r == S_DENS);
    cmd_o.commit = (state_r == S_CMP) && slot_free;
  end

  // Advance the sequencer and hold the result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_OFF;
          end
        end
        S_OFF:  state_r <= S_PROP;
        S_PROP: state_r <= S_SQ;
        S_SQ:   state_r <= S_EXP;
        S_EXP:  state_r <= S_DENS;
        S_DENS: state_r <= S_CMP;
        S_CMP: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cmd_o.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd_o))
    else $error("more than one sequencer command active");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction taken while one is in work");

endmodule

### hdl/msmp_dpath.sv
module msmp_dpath #(
  parameter int COUNT_WIDTH = 20,
  parameter int FRAC_BITS   = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msmp_pkg::msmp_cmd_t                 cmd_i,
  input  logic [msmp_pkg::DELTA_W-1:0]        delta_i,
  input  logic [msmp_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic [msmp_pkg::OUT_DATA_W-1:0]     out_data_o
);

  localparam int F_SHIFT = 2 * FRAC_BITS;
  localparam int K_SHIFT = 2 * FRAC_BITS + 17;
  localparam int IDX_LSB = 2 * FRAC_BITS + 11;
  localparam logic signed [15:0] POS_RESET = 16'(-(1 << (FRAC_BITS - 1)));
  localparam logic [15:0] DENS_RESET = msmp_pkg::density_const(POS_RESET, FRAC_BITS);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Walker state
  logic signed [15:0]       pos_r;
  logic [15:0]              dens_r;
  logic [COUNT_WIDTH-1:0]   cnt_r;

  // Per-step working registers
  logic [15:0]              u_r;
  logic [15:0]              r_r;
  logic [14:0]              off_r;
  logic [31:0]              rprod_r;
  logic signed [15:0]       prop_r;
  logic [msmp_pkg::SQ_W-1:0] sq_r;
  logic [4:0]               k_r;
  logic                     big_r;
  logic [5:0]               idx_r;
  logic [15:0]              fnew_r;

  // Result registers
  logic signed [15:0]       out_pos_r;
  logic                     out_acc_r;
  logic [msmp_pkg::TOTAL_W-1:0] out_total_r;

  logic [30:0]              off_prod;
  logic signed [17:0]       prop_sum;
  logic signed [15:0]       prop_sat;
  logic signed [31:0]       sq_full;
  logic [48:0]              tprod;
  logic [48:0]              k_full;
  logic [15:0]              e_sh;
  logic [46:0]              fprod;
  logic [46:0]              f_full;
  logic [15:0]              fnew;
  logic                     take;
  logic [COUNT_WIDTH-1:0]   cnt_nxt;
  logic signed [15:0]       pos_nxt;

  // Offset u*2*delta, keep the integer part
  assign off_prod = 31'(u_r) * 31'({delta_i, 1'b0});

  // Proposal, clamped to the position range
  assign prop_sum = 18'(pos_r) + $signed({3'b000, off_r}) - $signed({4'b0000, delta_i});
  always_comb begin
    if (prop_sum > 18'sd32767) begin
      prop_sat = 16'sh7FFF;
    end else if (prop_sum < -18'sd32768) begin
      prop_sat = 16'sh8000;
    end else begin
      prop_sat = prop_sum[15:0];
    end
  end

  assign sq_full = prop_r * prop_r;

  // Exponent x^2/2 * log2(e): integer part shifts, top fraction bits index
  assign tprod  = 49'(sq_r) * 49'(msmp_pkg::LOG2E_Q16);
  assign k_full = tprod >> K_SHIFT;

  // Density x^2 * 2^-k * table, saturated
  assign e_sh   = msmp_pkg::EXP_TABLE[idx_r] >> k_r;
  assign fprod  = 47'(sq_r) * 47'(e_sh);
  assign f_full = fprod >> F_SHIFT;
  always_comb begin
    if (big_r) begin
      fnew = 16'd0;
    end else if (f_full > 47'd65535) begin
      fnew = 16'hFFFF;
    end else begin
      fnew = f_full[15:0];
    end
  end

  // Acceptance test f(new) > r * f(old), ties reject
  assign take    = {fnew_r, 16'h0000} > rprod_r;
  assign cnt_nxt = (take && (cnt_r != CNT_MAX)) ? cnt_r + 1'b1 : cnt_r;
  assign pos_nxt = take ? prop_r : pos_r;

  // Hold the walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_RESET;
      dens_r <= DENS_RESET;
      cnt_r  <= '0;
    end else if (cmd_i.commit) begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      if (take) begin
        dens_r <= fnew_r;
      end
    end
  end

  // Step through the working registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      u_r <= in_data_i[15:0];
      r_r <= in_data_i[31:16];
    end
    if (cmd_i.off) begin
      off_r   <= off_prod[30:16];
      rprod_r <= 32'(r_r) * 32'(dens_r);
    end
    if (cmd_i.prop) begin
      prop_r <= prop_sat;
    end
    if (cmd_i.sq) begin
      sq_r <= sq_full[msmp_pkg::SQ_W-1:0];
    end
    if (cmd_i.expo) begin
      big_r <= (k_full > 49'd16);
      k_r   <= k_full[4:0];
      idx_r <= tprod[IDX_LSB +: 6];
    end
    if (cmd_i.dens) begin
      fnew_r <= fnew;
    end
    if (cmd_i.commit) begin
      out_pos_r   <= pos_nxt;
      out_acc_r   <= take;
      out_total_r <= msmp_pkg::TOTAL_W'(cnt_nxt);
    end
  end

  assign out_data_o = {3'b000, out_total_r, out_acc_r, out_pos_r};

  a_reject_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.commit && !take) |=> (pos_r == $past(pos_r)))
    else $error("rejected proposal moved the position");

  a_accept_takes_dens: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.commit && take) |=> (dens_r == $past(fnew_r)))
    else $error("accepted proposal did not update the density");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (cnt_r >= $past(cnt_r)))
    else $error("acceptance counter went backwards");

endmodule

### hdl/metropolis_sampler_step.sv
// Channel  | Direction | Handshake                        | Payload
// in_      | input     | in_tvalid / in_tready            | in_tdata: proposal, accept fractions
// out_     | output    | out_tvalid / out_tready          | out_tdata: position, accepted, total
// cfg_     | input     | cfg_psel / cfg_penable / pready  | step_half_width at address 0
//
// After acceptance a transaction walks the offset, proposal, square, exponent,
// density and test steps before its result is loaded; the next is taken only
// once the sequencer is back in idle, so no new transaction is taken while one
// is in work. The sequencer walks one shared datapath through these steps.
// Reset clears the sequencer, puts the walker at -0.5 with its density, zeroes
// the count and loads delta 2048. A result waits in the output register; the
// final test step holds until that register is free.
module metropolis_sampler_step #(
  parameter int COUNT_WIDTH = 20,
  parameter int FRAC_BITS   = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] proposal_uniform, [31:16] accept_uniform
  input  logic [msmp_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] sample_position, [16] accepted, [36:17] accept_total, [39:37] zero
  output logic [msmp_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [msmp_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [msmp_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [msmp_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  msmp_pkg::msmp_cmd_t               cmd;
  logic [msmp_pkg::DELTA_W-1:0]      delta_r;
  logic                              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == msmp_pkg::REG_STEP_HALF_WIDTH);

  // Hold the proposal half width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= msmp_pkg::DELTA_RESET;
    end else if (cfg_wr) begin
      delta_r <= cfg_pwdata[msmp_pkg::DELTA_W-1:0];
    end
  end

  // Read back the register, zero elsewhere
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == msmp_pkg::REG_STEP_HALF_WIDTH) begin
      cfg_prdata = msmp_pkg::CFG_DATA_W'(delta_r);
    end
  end

  msmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd_o      (cmd)
  );

  msmp_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .delta_i    (delta_r),
    .in_data_i  (in_tdata),
    .out_data_o (out_tdata)
  );

endmodule
